// ----- rtl/bpfa_pkg.sv -----
// Shared constants, types and helpers of the bitmap page frame allocator.
package bpfa_pkg;

    localparam int MAX_FRAMES  = 32768;
    localparam int FRAME_BYTES = 4096;
    localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
    localparam int WORD_W      = (MAX_FRAMES >= 64) ? 32 : 8;
    localparam int WB          = $clog2(WORD_W);
    localparam int NWORDS      = (MAX_FRAMES + WORD_W - 1) / WORD_W;
    localparam int AW          = $clog2(NWORDS);
    localparam int FW          = $clog2(MAX_FRAMES + 1);
    localparam int LW          = (FW + 1 > 17) ? FW + 1 : 17;
    localparam int RSV_RESET   = 1024;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BAD     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_BASE      = 2'd0,
        CFG_FCOUNT    = 2'd1,
        CFG_RSV_START = 2'd2,
        CFG_RSV_CNT   = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_SCAN,
        S_RD,
        S_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic          found;
        logic [WB-1:0] pos;
        logic [LW-1:0] run_out;
    } t_scan_res;

    function automatic logic [AW-1:0] word_of(input logic [FW-1:0] f);
        logic [FW-1:0] t;
        t = f >> WB;
        return t[AW-1:0];
    endfunction

endpackage

// ----- rtl/bpfa_ram.sv -----
// Generic single-port-write, registered-read RAM.
module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/bpfa_scan.sv -----
// Free-run detector over one bitmap word.
module bpfa_scan (
    input  logic [bpfa_pkg::WORD_W-1:0] i_word,
    input  logic [bpfa_pkg::FW-1:0]     i_base,
    input  logic [bpfa_pkg::FW-1:0]     i_cnt,
    input  logic [bpfa_pkg::LW-1:0]     i_run,
    input  logic [15:0]                 i_need,
    output bpfa_pkg::t_scan_res         o_res
);
    import bpfa_pkg::*;

    logic [WORD_W-1:0] free_v;
    logic [WORD_W-1:0] hit_v;
    logic [LW-1:0]     len [WORD_W];

    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            free_v[b] = !i_word[b] && ((LW'(i_base) + LW'(b)) < LW'(i_cnt));
        end
    end

    // run length ending at each bit, from the last blocked bit at or below it
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            len[b] = i_run + LW'(b + 1);
            for (int j = 0; j <= b; j++) begin
                if (!free_v[j]) begin
                    len[b] = LW'(b - j);
                end
            end
            hit_v[b] = len[b] >= LW'(i_need);
        end
    end

    always_comb begin
        o_res.found   = |hit_v;
        o_res.pos     = '0;
        o_res.run_out = len[WORD_W-1];
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (hit_v[b]) begin
                o_res.pos = WB'(b);
            end
        end
    end
endmodule

// ----- rtl/bitmap_page_frame_allocator.sv -----
// Top level: first-fit bitmap page frame allocator with sequencer and bitmap RAM.
// Free: read-modify-write of one bitmap word. Allocate: scan of one bitmap word per
// cycle (up to 1024 words), then a read and write-back per word marked. Init: a clear
// sweep of all 1024 words plus a read and write-back per reserved word. One request at
// a time; the next request is taken while a result waits in the output register. After
// reset a clear pass runs, accepting no request; config writes are taken at any time.
module bitmap_page_frame_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,    // run_length[15:0], frame_address[47:16]
    input  logic [1:0]  i_s_tuser,    // operation[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,    // result_address[31:0], status[33:32], zero pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import bpfa_pkg::*;

    t_state          r_state, n_state;
    logic [31:0]     r_base, r_rsa;
    logic [15:0]     r_fcount, r_rfr;
    logic [AW-1:0]   r_cw, r_w, r_lastw, r_dw;
    logic [AW:0]     r_sa;
    logic            r_do_rsv, r_set, r_dv, r_is_alloc, r_ov;
    logic [15:0]     r_n;
    logic [FW-1:0]   r_lo, r_hi;
    logic [LW-1:0]   r_run;
    t_status         r_res_st, r_out_st;
    logic [31:0]     r_out_addr;

    logic            s_acc, out_load, scan_issue;
    logic [FW-1:0]   cnt, rsv_hi, scan_hit, scan_lo, dbase;
    logic [31:0]     free_idx, rsv_first;
    logic [32:0]     rsv_end;
    logic            free_bad, rsv_none;
    logic [WB-1:0]   lo_off, hi_off;
    logic [WORD_W-1:0] mask, mod_word, ram_rdata, ram_wdata;
    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    t_scan_res       scan;
    logic [LW-1:0]   lo_wide;

    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_load    = (r_state == S_DONE) && (!r_ov || i_m_tready);
    assign o_m_tvalid  = r_ov;
    assign o_m_tdata   = {6'b0, r_out_st, r_out_addr};

    assign cnt = (32'(r_fcount) >= 32'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : FW'(r_fcount);

    assign free_idx  = (i_s_tdata[47:16] - r_base) >> FRAME_SHIFT;
    assign free_bad  = (i_s_tdata[47:16] < r_base) || (free_idx >= 32'(cnt));
    assign rsv_first = (r_rsa - r_base) >> FRAME_SHIFT;
    assign rsv_end   = {1'b0, rsv_first} + 33'(r_rfr);
    assign rsv_none  = (r_rfr == 16'd0) || (rsv_first >= 32'(cnt));
    assign rsv_hi    = (rsv_end >= 33'(cnt)) ? FW'(cnt - 1'b1) : FW'(rsv_end - 33'd1);

    assign dbase    = FW'(r_dw) << WB;
    assign scan_hit = dbase + FW'(scan.pos);
    assign lo_wide  = LW'(scan_hit) + LW'(1) - LW'(r_n);
    assign scan_lo  = lo_wide[FW-1:0];
    assign scan_issue = (r_sa <= {1'b0, r_lastw}) && !(r_dv && scan.found);

    assign lo_off   = (r_w == word_of(r_lo)) ? r_lo[WB-1:0] : '0;
    assign hi_off   = (r_w == word_of(r_hi)) ? r_hi[WB-1:0] : WB'(WORD_W - 1);
    assign mask     = ({WORD_W{1'b1}} << lo_off) &
                      ({WORD_W{1'b1}} >> (WB'(WORD_W - 1) - hi_off));
    assign mod_word = r_set ? (ram_rdata | mask) : (ram_rdata & ~mask);

    bpfa_ram #(.WIDTH(WORD_W), .DEPTH(NWORDS)) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bpfa_scan u_scan (
        .i_word (ram_rdata),
        .i_base (dbase),
        .i_cnt  (cnt),
        .i_run  (r_run),
        .i_need (r_n),
        .o_res  (scan)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_cw == AW'(NWORDS - 1)) begin
                    if (!r_do_rsv) n_state = S_IDLE;
                    else if (rsv_none) n_state = S_DONE;
                    else n_state = S_RD;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    case (i_s_tuser)
                        OP_INIT:  n_state = S_CLR;
                        OP_ALLOC: n_state = (i_s_tdata[15:0] == 16'd0 || cnt == '0) ?
                                            S_DONE : S_SCAN;
                        OP_FREE:  n_state = free_bad ? S_DONE : S_RD;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_dv && scan.found) n_state = S_RD;
                else if (r_dv && r_dw == r_lastw) n_state = S_DONE;
            end
            S_RD:   n_state = S_WR;
            S_WR:   n_state = (r_w == word_of(r_hi)) ? S_DONE : S_RD;
            S_DONE: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_w;
        ram_wdata = mod_word;
        ram_re    = 1'b0;
        ram_raddr = r_w;
        case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cw;
                ram_wdata = '0;
            end
            S_SCAN: begin
                ram_re    = scan_issue;
                ram_raddr = r_sa[AW-1:0];
            end
            S_RD: ram_re = 1'b1;
            S_WR: ram_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cw     <= '0;
            r_do_rsv <= 1'b0;
            r_ov     <= 1'b0;
            r_dv     <= 1'b0;
            r_base   <= 32'd0;
            r_fcount <= 16'(MAX_FRAMES);
            r_rsa    <= 32'h0010_0000;
            r_rfr    <= 16'(RSV_RESET);
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BASE:      r_base   <= i_cfg_data;
                    CFG_FCOUNT:    r_fcount <= i_cfg_data[15:0];
                    CFG_RSV_START: r_rsa    <= i_cfg_data;
                    CFG_RSV_CNT:   r_rfr    <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                r_ov       <= 1'b1;
                r_out_st   <= r_res_st;
                r_out_addr <= (r_is_alloc && r_res_st == ST_OK) ?
                              r_base + (32'(r_lo) << FRAME_SHIFT) : 32'd0;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_cw <= r_cw + 1'b1;
                    if (r_cw == AW'(NWORDS - 1)) begin
                        r_do_rsv <= 1'b0;
                        r_lo     <= FW'(rsv_first);
                        r_hi     <= rsv_hi;
                        r_w      <= word_of(FW'(rsv_first));
                        r_set    <= 1'b1;
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        r_n        <= i_s_tdata[15:0];
                        r_sa       <= '0;
                        r_dv       <= 1'b0;
                        r_run      <= '0;
                        r_cw       <= '0;
                        r_lastw    <= word_of(FW'(cnt - 1'b1));
                        r_is_alloc <= (i_s_tuser == OP_ALLOC);
                        case (i_s_tuser)
                            OP_INIT: begin
                                r_do_rsv <= 1'b1;
                                r_res_st <= ST_OK;
                            end
                            OP_ALLOC: begin
                                if (i_s_tdata[15:0] == 16'd0) r_res_st <= ST_BAD;
                                else if (cnt == '0) r_res_st <= ST_NOSPACE;
                                else r_res_st <= ST_OK;
                            end
                            OP_FREE: begin
                                r_res_st <= free_bad ? ST_BAD : ST_OK;
                                r_lo     <= FW'(free_idx);
                                r_hi     <= FW'(free_idx);
                                r_w      <= word_of(FW'(free_idx));
                                r_set    <= 1'b0;
                            end
                            default: r_res_st <= ST_BAD;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_dv <= scan_issue;
                    r_dw <= r_sa[AW-1:0];
                    if (scan_issue) r_sa <= r_sa + 1'b1;
                    if (r_dv) begin
                        r_run <= scan.run_out;
                        if (scan.found) begin
                            r_hi  <= scan_hit;
                            r_lo  <= scan_lo;
                            r_w   <= word_of(scan_lo);
                            r_set <= 1'b1;
                        end else if (r_dw == r_lastw) begin
                            r_res_st <= ST_NOSPACE;
                        end
                    end
                end
                S_WR: r_w <= r_w + 1'b1;
                default: ;
            endcase
        end
    end

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !ram_we)
        else $error("bitmap written during scan");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> ($past(r_state) == S_RD))
        else $error("write-back without preceding read");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> ($past(r_state) == S_DONE))
        else $error("result presented outside completion");
endmodule
